### hw/rtl/swr_pkg.sv
// Shared constants, types and helper functions for the stream word replacer.
package swr_pkg;

    localparam int MAX_WORD  = 8;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 64;
    localparam int LEN_W     = 4;
    localparam int FILL_W    = $clog2(MAX_WORD);
    localparam int CNT_W     = 24;
    localparam int CFG_IDX_W = 2;
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = $clog2(QDEPTH);

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN  = 2'd0,
        CFG_PAT_LEN  = 2'd1,
        CFG_REPL     = 2'd2,
        CFG_REPL_LEN = 2'd3
    } t_cfg_idx;

    // One output run: up to MAX_WORD bytes, or a single empty result when cnt is zero.
    typedef struct packed {
        logic [WORD_W-1:0] data;
        logic [LEN_W-1:0]  cnt;
        logic              done;
        logic [CNT_W-1:0]  total;
    } t_cmd;

    // Queue status seen by the front and back parts.
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // Pattern length in use: at least one byte, at most MAX_WORD.
    function automatic logic [LEN_W-1:0] eff_plen(input logic [LEN_W-1:0] v);
        if (v == '0) begin
            return LEN_W'(1);
        end else if (v > LEN_W'(MAX_WORD)) begin
            return LEN_W'(MAX_WORD);
        end
        return v;
    endfunction

    // Replacement length in use: at most MAX_WORD.
    function automatic logic [LEN_W-1:0] eff_rlen(input logic [LEN_W-1:0] v);
        if (v > LEN_W'(MAX_WORD)) begin
            return LEN_W'(MAX_WORD);
        end
        return v;
    endfunction

endpackage

### hw/rtl/swr_in_if.sv
// Input channel: one text byte per item with its end-of-stream flag.
interface swr_in_if
    import swr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink   (input valid, input in_byte, input end_of_stream, output ready);
endinterface

### hw/rtl/swr_out_if.sv
// Output channel: one edited-stream result per item.
interface swr_out_if
    import swr_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              last_of_run;
    logic              stream_done;
    logic [CNT_W-1:0]  replace_total;

    modport source (output valid, output out_byte, output byte_valid, output last_of_run,
                    output stream_done, output replace_total, input ready);
    modport sink   (input valid, input out_byte, input byte_valid, input last_of_run,
                    input stream_done, input replace_total, output ready);
endinterface

### hw/rtl/swr_front.sv
// Front part: holds configuration and the pending window, matches and issues output runs.
module swr_front
    import swr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_wdata,
    swr_in_if.sink               i_in,
    input  t_q_stat              i_qstat,
    output logic                 o_push,
    output t_cmd                 o_cmd
);

    logic [WORD_W-1:0] r_pattern;
    logic [LEN_W-1:0]  r_plen_raw;
    logic [WORD_W-1:0] r_repl;
    logic [LEN_W-1:0]  r_rlen_raw;

    logic [BYTE_W-1:0] r_win [MAX_WORD];
    logic [BYTE_W-1:0] n_win [MAX_WORD];
    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] n_fill;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic [BYTE_W-1:0] w_app [MAX_WORD];
    logic [WORD_W-1:0] w_packed;
    logic [LEN_W-1:0]  plen;
    logic [LEN_W-1:0]  rlen;
    logic [LEN_W-1:0]  fill_app;
    logic [CNT_W-1:0]  count_inc;
    logic              full_win;
    logic              hit;
    logic              accept;
    logic              eos;
    logic              plen_wr;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign eos        = i_in.end_of_stream;
    assign plen       = eff_plen(r_plen_raw);
    assign rlen       = eff_rlen(r_rlen_raw);
    assign fill_app   = LEN_W'(r_fill) + LEN_W'(1);
    assign full_win   = (fill_app == plen);
    assign count_inc  = (r_count != COUNT_MAX) ? r_count + CNT_W'(1) : r_count;
    assign plen_wr    = i_cfg_we && (t_cfg_idx'(i_cfg_idx) == CFG_PAT_LEN);

    // Window with the new byte appended, and the pattern compare over it.
    always_comb begin
        hit = full_win;
        for (int i = 0; i < MAX_WORD; i++) begin
            w_app[i] = (FILL_W'(i) == r_fill) ? i_in.in_byte : r_win[i];
            w_packed[i*BYTE_W +: BYTE_W] = w_app[i];
            if ((LEN_W'(i) < plen) && (w_app[i] != r_pattern[i*BYTE_W +: BYTE_W])) begin
                hit = 1'b0;
            end
        end
    end

    // Output run issued for this item.
    always_comb begin
        o_cmd.done  = eos;
        o_cmd.total = hit ? count_inc : r_count;
        if (hit) begin
            o_cmd.data = r_repl;
            o_cmd.cnt  = rlen;
            o_push     = accept && ((rlen != '0) || eos);
        end else begin
            o_cmd.data = w_packed;
            o_cmd.cnt  = eos ? fill_app : LEN_W'(1);
            o_push     = accept && (full_win || eos);
        end
    end

    // Next window, fill level and replacement count.
    always_comb begin
        n_count = r_count;
        n_fill  = r_fill;
        for (int i = 0; i < MAX_WORD; i++) begin
            n_win[i] = w_app[i];
        end
        if (eos) begin
            n_fill  = '0;
            n_count = '0;
        end else if (hit) begin
            n_fill  = '0;
            n_count = count_inc;
        end else if (full_win) begin
            // Oldest byte leaves: the window slides down by one.
            for (int i = 0; i < MAX_WORD - 1; i++) begin
                n_win[i] = w_app[i+1];
            end
            n_fill = r_fill;
        end else begin
            n_fill = r_fill + FILL_W'(1);
        end
    end

    // Control state and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern  <= '0;
            r_plen_raw <= LEN_W'(1);
            r_repl     <= '0;
            r_rlen_raw <= '0;
            r_fill     <= '0;
            r_count    <= '0;
        end else begin
            // A pattern length write discards the pending window.
            if (plen_wr) begin
                r_fill <= '0;
            end else if (accept) begin
                r_fill <= n_fill;
            end
            if (accept) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_PATTERN: begin
                        r_pattern <= i_cfg_wdata;
                    end
                    CFG_PAT_LEN: begin
                        r_plen_raw <= i_cfg_wdata[LEN_W-1:0];
                    end
                    CFG_REPL: begin
                        r_repl <= i_cfg_wdata;
                    end
                    CFG_REPL_LEN: begin
                        r_rlen_raw <= i_cfg_wdata[LEN_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Window bytes hold no meaning until written.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

### hw/rtl/swr_queue.sv
// Short queue of output runs between the front and back parts.
module swr_queue
    import swr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_head,
    output t_q_stat o_stat
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_stat.full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];

    // Pointers and occupancy.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QPTR_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QPTR_W+1)'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

### hw/rtl/swr_back.sv
// Back part: walks the head run and sends one result per item.
module swr_back
    import swr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_head,
    input  t_q_stat   i_qstat,
    output logic      o_pop,
    swr_out_if.source o_out
);

    logic [FILL_W-1:0] r_idx;
    logic [FILL_W-1:0] n_idx;
    logic              is_null;
    logic              last;
    logic              take;

    assign is_null = (i_head.cnt == '0);
    assign last    = is_null || (LEN_W'(r_idx) == i_head.cnt - LEN_W'(1));
    assign take    = o_out.valid && o_out.ready;
    assign o_pop   = take && last;

    // Result fields from the head run.
    always_comb begin
        o_out.valid         = !i_qstat.empty;
        o_out.byte_valid    = !is_null;
        o_out.out_byte      = is_null ? '0 : i_head.data[{r_idx, 3'b000} +: BYTE_W];
        o_out.last_of_run   = last;
        o_out.stream_done   = i_head.done && last;
        o_out.replace_total = i_head.total;
    end

    // Byte position inside the run.
    always_comb begin
        n_idx = r_idx;
        if (o_pop) begin
            n_idx = '0;
        end else if (take) begin
            n_idx = r_idx + FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

### hw/rtl/stream_word_replace.sv
// Stream find-and-replace: top level joining front part, run queue and back part.
// The first result of an item is registered in the run queue and offered by the back part from there.
// Throughput: one item per cycle while each item yields at most one result and the output is ready; an item
// that yields k results holds the single output port of the back part until all k are sent.
// Reset: synchronous, active low; clears the window fill, count, queue and config.
module stream_word_replace
    import swr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_wdata,
    swr_in_if.sink               i_in,
    swr_out_if.source            o_out
);

    t_cmd    cmd;
    t_cmd    head;
    t_q_stat qstat;
    logic    push;
    logic    pop;

    swr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_qstat     (qstat),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    swr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (qstat)
    );

    swr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

    // A result without a character only ever closes a stream.
    a_null_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.byte_valid) |->
            (o_out.last_of_run && o_out.stream_done && (o_out.out_byte == '0)))
        else $error("empty result does not close the stream");

    // The end of a stream is also the end of a run.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stream_done) |-> o_out.last_of_run)
        else $error("stream_done without last_of_run");

    // The queue is never both full and empty.
    a_queue_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue status inconsistent");

    // Nothing is offered right after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("output valid right after reset");

endmodule
